>>> rtl/kdeh_pkg.sv
// ----------------------------------------------------------------------------
// Key debounce and hold timer package
// Shared types, codes and defaults for the key debouncer with long-press hold.
// ----------------------------------------------------------------------------
`default_nettype none

package kdeh_pkg;

  // Fixed widths of the key fields, counters, hold timer and configuration.
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned CONF_W  = 2;
  localparam int unsigned CFG_W   = 16;

  // Default number of debounced keys.
  localparam int unsigned KEY_COUNT_DEF = 4;

  // Request kinds.
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEBOUNCE_LIMIT = 2'd0;
  localparam cfg_idx_t CFG_HOLD_TICKS     = 2'd1;
  localparam cfg_idx_t CFG_CONFIRM_KEY    = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]  LIMIT_RST   = 8'd20;
  localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd3000;
  localparam logic [CONF_W-1:0] CONFIRM_RST = 2'd0;

  // Hold timer phases.
  typedef enum logic [1:0] {
    HOLD_IDLE     = 2'd0,
    HOLD_COUNTING = 2'd1,
    HOLD_REACHED  = 2'd2
  } hold_phase_e;

  // Input request: a key scan sample or a hold timer tick.
  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] raw_keys;
  } kdeh_in_t;

  // Result of one request.
  typedef struct packed {
    logic [KEY_W-1:0] stable_keys;
    logic [KEY_W-1:0] press_edges;
    logic [KEY_W-1:0] release_edges;
    logic [1:0]       hold_state;
  } kdeh_out_t;

endpackage : kdeh_pkg

`default_nettype wire

>>> rtl/key_debounce_edge_hold.sv
// Path: a request is held in the input register, then passes the compute stage
// into the result register, where it waits until it is taken.
// Throughput: one request per cycle while results are taken; the per-key counters and the hold timer
// all update in the single compute stage between the two registers.
// Reset clears the debounce counters, the stable keys and the hold timer, and
// loads the configuration registers with limit 20, hold 3000 ticks, key 0.
// ----------------------------------------------------------------------------
// Integrating key debouncer with edge detection and long-press hold
// Debounces each key with an up/down counter, reports press and release edges
// per scan, and times a long press of the confirm key in timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_edge_hold #(
  parameter int unsigned KeyCount = kdeh_pkg::KEY_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire kdeh_pkg::kdeh_in_t   in_data_i,
  // Result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output kdeh_pkg::kdeh_out_t       out_data_o,
  // Configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire kdeh_pkg::cfg_idx_t   cfg_index_i,
  input  wire logic [kdeh_pkg::CFG_W-1:0] cfg_data_i
);

  import kdeh_pkg::*;

  localparam int unsigned ExtW = KeyCount + KEY_W;

  // Configuration registers
  logic [CNT_W-1:0]  limit_q;
  logic [HOLD_W-1:0] hold_ticks_q;
  logic [CONF_W-1:0] confirm_q;

  // Pipeline registers
  logic      s1_valid_q, s1_valid_d;
  kdeh_in_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  kdeh_out_t out_data_q, out_data_d;
  logic      in_accept;
  logic      advance;

  // Block state
  logic [CNT_W-1:0]    cnt_q [KeyCount];
  logic [CNT_W-1:0]    cnt_d [KeyCount];
  logic [KeyCount-1:0] filt_q, filt_d, filt_scan;
  hold_phase_e         phase_q, phase_d;
  logic [HOLD_W-1:0]   rem_q, rem_d;

  // Compute stage signals
  logic                is_scan;
  logic [ExtW-1:0]     raw_ext;
  logic [KeyCount-1:0] raw_k;
  logic [ExtW-1:0]     confirm_ext;
  logic [KeyCount-1:0] confirm_mask;
  logic [KeyCount-1:0] press, release_k;
  logic                confirm_press, confirm_release;
  logic                rem_last;
  logic [ExtW-1:0]     stable_ext, press_ext, release_ext;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= LIMIT_RST;
      hold_ticks_q <= HOLD_RST;
      confirm_q    <= CONFIRM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_LIMIT: limit_q      <= cfg_data_i[CNT_W-1:0];
        CFG_HOLD_TICKS:     hold_ticks_q <= cfg_data_i[HOLD_W-1:0];
        CFG_CONFIRM_KEY:    confirm_q    <= cfg_data_i[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the compute stage moves whenever the result register is free.
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Widen the fixed raw field to the key count; missing keys read low.
  assign is_scan = (s1_data_q.kind == KIND_SCAN);
  assign raw_ext = {{KeyCount{1'b0}}, s1_data_q.raw_keys};
  assign raw_k   = raw_ext[KeyCount-1:0];

  // One-hot mask of the confirm key; an index past the last key matches none.
  assign confirm_ext  = ExtW'(1) << confirm_q;
  assign confirm_mask = confirm_ext[KeyCount-1:0];

  // Per-key integrating counters.
  always_comb begin
    for (int k = 0; k < KeyCount; k++) begin
      cnt_d[k]     = cnt_q[k];
      filt_scan[k] = filt_q[k];
      if (is_scan) begin
        if (raw_k[k]) begin
          // Count up to one past the limit; the bit sets when the limit is passed.
          if ((cnt_q[k] <= limit_q) && (cnt_q[k] != {CNT_W{1'b1}})) begin
            cnt_d[k] = cnt_q[k] + CNT_W'(1);
            if (cnt_q[k] == limit_q) begin
              filt_scan[k] = 1'b1;
            end
          end
        end else if (cnt_q[k] != '0) begin
          // Count down; the bit clears when the counter reaches zero.
          cnt_d[k] = cnt_q[k] - CNT_W'(1);
          if (cnt_q[k] == CNT_W'(1)) begin
            filt_scan[k] = 1'b0;
          end
        end
      end
    end
  end

  // Edges against the previous scan's stable state.
  assign filt_d    = filt_scan;
  assign press     = is_scan ? (filt_scan & ~filt_q) : '0;
  assign release_k = is_scan ? (filt_q & ~filt_scan) : '0;

  assign confirm_press   = |(press & confirm_mask);
  assign confirm_release = |(release_k & confirm_mask);
  assign rem_last        = (rem_q <= HOLD_W'(1));

  // Hold timer next state.
  always_comb begin
    phase_d = phase_q;
    if (is_scan) begin
      if (confirm_release) begin
        phase_d = HOLD_IDLE;
      end else if (confirm_press) begin
        phase_d = HOLD_COUNTING;
      end
    end else begin
      unique case (phase_q)
        HOLD_IDLE:     phase_d = HOLD_IDLE;
        HOLD_COUNTING: phase_d = rem_last ? HOLD_REACHED : HOLD_COUNTING;
        HOLD_REACHED:  phase_d = HOLD_REACHED;
        default:       phase_d = phase_q;
      endcase
    end
  end

  // Hold timer countdown.
  always_comb begin
    rem_d = rem_q;
    if (is_scan) begin
      if (confirm_release) begin
        rem_d = '0;
      end else if (confirm_press) begin
        rem_d = hold_ticks_q;
      end
    end else if (phase_q == HOLD_COUNTING) begin
      rem_d = rem_last ? '0 : (rem_q - HOLD_W'(1));
    end
  end

  // Result assembly, narrowed back to the fixed field width.
  assign stable_ext  = {{KEY_W{1'b0}}, filt_d};
  assign press_ext   = {{KEY_W{1'b0}}, press};
  assign release_ext = {{KEY_W{1'b0}}, release_k};

  always_comb begin
    out_data_d.stable_keys   = stable_ext[KEY_W-1:0];
    out_data_d.press_edges   = press_ext[KEY_W-1:0];
    out_data_d.release_edges = release_ext[KEY_W-1:0];
    out_data_d.hold_state    = phase_d;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      filt_q      <= '0;
      phase_q     <= HOLD_IDLE;
      rem_q       <= '0;
      for (int k = 0; k < KeyCount; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        filt_q  <= filt_d;
        phase_q <= phase_d;
        rem_q   <= rem_d;
        for (int k = 0; k < KeyCount; k++) begin
          cnt_q[k] <= cnt_d[k];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule : key_debounce_edge_hold

`default_nettype wire

>>> rtl/kdeh_checker.sv
// ----------------------------------------------------------------------------
// Key debounce and hold port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module kdeh_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire kdeh_pkg::kdeh_out_t  out_data_o
);

  import kdeh_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // An empty result register never blocks a new request.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty result register");

  // A key cannot be pressed and released on the same scan.
  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.press_edges & out_data_o.release_edges) == '0))
    else $error("press and release edge on the same key");

  // Edges agree with the reported stable state.
  a_edges_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((out_data_o.press_edges & ~out_data_o.stable_keys) == '0) &&
                     ((out_data_o.release_edges & out_data_o.stable_keys) == '0)))
    else $error("edge mask disagrees with stable keys");

endmodule : kdeh_checker

bind key_debounce_edge_hold kdeh_checker u_kdeh_checker (.*);

`default_nettype wire
